[hw/rtl/hndm_pkg.sv]
package hndm_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 4;
    localparam int DESC_W    = WORD_W * NUM_WORDS;
    localparam int COORD_W   = 128;
    localparam int DIST_W    = 9;
    localparam int POP_W     = 7;
    localparam int THR_W     = 9;
    localparam int INDEX_W   = 8;

    localparam int S_TDATA_W = DESC_W + COORD_W;
    localparam int M_TDATA_W = 152;
    localparam int M_USED_W  = DIST_W + INDEX_W + COORD_W;

    localparam logic [THR_W-1:0]  THR_RESET     = 9'd80;
    localparam logic [DIST_W-1:0] NO_MATCH_DIST = 9'd256;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] best;
        logic [ADDR_W-1:0] idx;
    } scan_res_t;

    function automatic logic [INDEX_W-1:0] to_index(input logic [ADDR_W-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[INDEX_W-1:0];
    endfunction

endpackage

[hw/rtl/hndm_ram.sv]
module hndm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/hndm_scan.sv]
module hndm_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [hndm_pkg::CNT_W-1:0]    count,
    input  logic [hndm_pkg::DESC_W-1:0]   q_desc,
    input  logic [hndm_pkg::DESC_W-1:0]   rd_data,
    output logic                          rd_en,
    output logic [hndm_pkg::ADDR_W-1:0]   rd_addr,
    output hndm_pkg::scan_res_t           res
);

    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] s;
        s = 4'd0;
        for (int i = 0; i < 8; i++) begin
            s = s + 4'(b[i]);
        end
        return s;
    endfunction

    function automatic logic [hndm_pkg::POP_W-1:0] pop64(input logic [63:0] v);
        logic [hndm_pkg::POP_W-1:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + hndm_pkg::POP_W'(pop8(v[i*8 +: 8]));
        end
        return s;
    endfunction

    logic                          issuing_reg, issuing_next;
    logic [hndm_pkg::CNT_W-1:0]    addr_reg, addr_next;
    logic [hndm_pkg::CNT_W-1:0]    addr_inc;
    logic                          rd_vld_reg, rd_last_reg;
    logic [hndm_pkg::ADDR_W-1:0]   rd_idx_reg;
    logic                          a_vld_reg, a_last_reg;
    logic [hndm_pkg::ADDR_W-1:0]   a_idx_reg;
    logic [hndm_pkg::POP_W-1:0]    pop_reg [hndm_pkg::NUM_WORDS];
    logic [hndm_pkg::DIST_W-1:0]   cur_dist;
    logic [hndm_pkg::DIST_W-1:0]   best_reg;
    logic [hndm_pkg::ADDR_W-1:0]   best_idx_reg;
    logic                          done_reg;

    assign addr_inc = addr_reg + 1'b1;
    assign rd_en    = issuing_reg;
    assign rd_addr  = addr_reg[hndm_pkg::ADDR_W-1:0];

    always_comb begin
        issuing_next = issuing_reg;
        addr_next    = addr_reg;
        if (start) begin
            issuing_next = (count != '0);
            addr_next    = '0;
        end else if (issuing_reg) begin
            addr_next = addr_inc;
            if (addr_inc == count) begin
                issuing_next = 1'b0;
            end
        end
    end

    always_comb begin
        cur_dist = '0;
        for (int k = 0; k < hndm_pkg::NUM_WORDS; k++) begin
            cur_dist = cur_dist + hndm_pkg::DIST_W'(pop_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issuing_reg <= 1'b0;
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            a_vld_reg   <= 1'b0;
            a_last_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            issuing_reg <= issuing_next;
            addr_reg    <= addr_next;
            rd_vld_reg  <= issuing_reg;
            rd_last_reg <= issuing_reg && (addr_inc == count);
            a_vld_reg   <= rd_vld_reg;
            a_last_reg  <= rd_vld_reg && rd_last_reg;
            done_reg    <= a_vld_reg && a_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_addr;
        a_idx_reg  <= rd_idx_reg;
        if (rd_vld_reg) begin
            for (int k = 0; k < hndm_pkg::NUM_WORDS; k++) begin
                pop_reg[k] <= pop64(rd_data[k*hndm_pkg::WORD_W +: hndm_pkg::WORD_W]
                                    ^ q_desc[k*hndm_pkg::WORD_W +: hndm_pkg::WORD_W]);
            end
        end
        if (start) begin
            best_reg     <= hndm_pkg::NO_MATCH_DIST;
            best_idx_reg <= '0;
        end else if (a_vld_reg && (cur_dist < best_reg)) begin
            best_reg     <= cur_dist;
            best_idx_reg <= a_idx_reg;
        end
    end

    assign res.done = done_reg;
    assign res.best = best_reg;
    assign res.idx  = best_idx_reg;

endmodule

[hw/rtl/hamming_nearest_descriptor_match.sv]
// Clear and append: the next transfer is taken in the following cycle.
// Query: an empty table skips the scan; otherwise the descriptor memory scan (one stored
//   entry read per cycle), the scan pipeline and the coordinate read lie between the input
//   transfer and result valid.
// A finished result waits in the output register while clear and append transfers continue.
// Reset (aresetn low, synchronous): entry count 0, threshold 80, no result pending;
//   the descriptor and coordinate memories are not cleared.
module hamming_nearest_descriptor_match (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [hndm_pkg::THR_W-1:0]       cfg_wr_data,  // accept_threshold
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // desc_word0, desc_word1, desc_word2, desc_word3,
    // entry_pix_x, entry_pix_y, entry_norm_x, entry_norm_y
    input  logic [hndm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [1:0]                       s_tuser,      // op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // best_distance, match_index, match_pix_x, match_pix_y,
    // match_norm_x, match_norm_y, zero fill
    output logic [hndm_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [0:0]                       m_tuser       // found
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUTPUT
    } state_t;

    state_t                          state_reg;
    logic [hndm_pkg::CNT_W-1:0]      count_reg;
    logic [hndm_pkg::THR_W-1:0]      thr_reg;
    logic [hndm_pkg::DESC_W-1:0]     q_desc_reg;
    logic                            m_tvalid_reg;
    logic [hndm_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic [hndm_pkg::M_TDATA_W-1:0]  m_tdata_next;
    logic [0:0]                      m_tuser_reg;

    logic                            s_xfer;
    logic                            do_append;
    logic                            do_query;
    logic                            scan_rd_en;
    logic [hndm_pkg::ADDR_W-1:0]     scan_rd_addr;
    hndm_pkg::scan_res_t             scan_res;
    logic [hndm_pkg::DESC_W-1:0]     desc_rdata;
    logic [hndm_pkg::COORD_W-1:0]    coord_rdata;
    logic                            desc_en;
    logic [hndm_pkg::ADDR_W-1:0]     desc_addr;
    logic                            coord_en;
    logic [hndm_pkg::ADDR_W-1:0]     coord_addr;
    logic                            found;
    logic                            out_load;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign do_append = s_xfer && (s_tuser == hndm_pkg::OP_APPEND)
                       && (count_reg < hndm_pkg::CNT_W'(hndm_pkg::TABLE_DEPTH));
    assign do_query  = s_xfer && (s_tuser == hndm_pkg::OP_QUERY);

    assign desc_en    = do_append || scan_rd_en;
    assign desc_addr  = do_append ? count_reg[hndm_pkg::ADDR_W-1:0] : scan_rd_addr;
    assign coord_en   = do_append || ((state_reg == ST_SCAN) && scan_res.done);
    assign coord_addr = do_append ? count_reg[hndm_pkg::ADDR_W-1:0] : scan_res.idx;

    assign found    = (count_reg != '0) && (hndm_pkg::DIST_W'(scan_res.best) < thr_reg);
    assign out_load = (state_reg == ST_OUTPUT) && (!m_tvalid_reg || m_tready);

    hndm_ram #(
        .WIDTH (hndm_pkg::DESC_W),
        .DEPTH (hndm_pkg::TABLE_DEPTH)
    ) u_desc_ram (
        .clk   (aclk),
        .en    (desc_en),
        .we    (do_append),
        .addr  (desc_addr),
        .wdata (s_tdata[hndm_pkg::DESC_W-1:0]),
        .rdata (desc_rdata)
    );

    hndm_ram #(
        .WIDTH (hndm_pkg::COORD_W),
        .DEPTH (hndm_pkg::TABLE_DEPTH)
    ) u_coord_ram (
        .clk   (aclk),
        .en    (coord_en),
        .we    (do_append),
        .addr  (coord_addr),
        .wdata (s_tdata[hndm_pkg::S_TDATA_W-1:hndm_pkg::DESC_W]),
        .rdata (coord_rdata)
    );

    hndm_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (do_query),
        .count   (count_reg),
        .q_desc  (q_desc_reg),
        .rd_data (desc_rdata),
        .rd_en   (scan_rd_en),
        .rd_addr (scan_rd_addr),
        .res     (scan_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            thr_reg      <= hndm_pkg::THR_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_xfer && (s_tuser == hndm_pkg::OP_CLEAR)) begin
                        count_reg <= '0;
                    end
                    if (do_append) begin
                        count_reg <= count_reg + 1'b1;
                    end
                    if (do_query) begin
                        state_reg <= (count_reg == '0) ? ST_OUTPUT : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_res.done) begin
                        state_reg <= ST_OUTPUT;
                    end
                end
                ST_OUTPUT: begin
                    if (out_load) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[hndm_pkg::DIST_W-1:0] = scan_res.best;
        if (found) begin
            m_tdata_next[hndm_pkg::DIST_W +: hndm_pkg::INDEX_W] =
                hndm_pkg::to_index(scan_res.idx);
            m_tdata_next[hndm_pkg::DIST_W + hndm_pkg::INDEX_W +: hndm_pkg::COORD_W] =
                coord_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_query) begin
            q_desc_reg <= s_tdata[hndm_pkg::DESC_W-1:0];
        end
        if (out_load) begin
            m_tuser_reg <= found;
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[hw/rtl/hndm_checker.sv]
module hndm_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [1:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [hndm_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [0:0]                       m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == hndm_pkg::OP_QUERY) |=> !s_tready)
        else $error("input taken right after a query transfer");

    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a query in progress");

    a_no_match_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            (m_tdata[hndm_pkg::M_TDATA_W-1:hndm_pkg::DIST_W] == '0))
        else $error("no-match result carries index or coordinates");

endmodule

bind hamming_nearest_descriptor_match hndm_checker u_hndm_checker (.*);
